FILE: src/fse_pkg.sv
// Shared types, constants and helpers for the foot support estimator.
// Used by every module of the block; depends on nothing.
`default_nettype none
package fse_pkg;

  localparam int unsigned NumLanes  = 8;
  localparam int unsigned LaneIdxW  = 3;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned FracW     = 14;
  localparam int unsigned NormW     = 15;
  localparam int unsigned WeightW   = 15;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned SupportW  = 16;
  localparam int unsigned InDataW   = NumLanes * SampleW + TimeW;
  localparam int unsigned OutDataW  = 24;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  // lane divider: (p << 14) / peak, one quotient bit per cycle
  localparam int unsigned LaneSteps = SampleW + FracW;
  localparam int unsigned LaneCntW  = 5;

  // merge: weighted sum over the total, one quotient bit per cycle
  localparam int unsigned WsumW     = 34;
  localparam int unsigned MagW      = 33;
  localparam int unsigned TotalW    = 18;
  localparam int unsigned MergeCntW = 6;

  localparam logic [SampleW-1:0] PeakFloor    = 16'd410;
  localparam logic [TimeW-1:0]   SwapPeriodMs = 32'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OUTER_W = 3'd0,
    CFG_INNER_W = 3'd1,
    CFG_MAX_P   = 3'd2,
    CFG_ARM_TH  = 3'd3,
    CFG_HC_W    = 3'd4,
    CFG_HC_V    = 3'd5,
    CFG_LC_W    = 3'd6,
    CFG_LC_V    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {T_IDLE, T_LANE, T_MERGE, T_HOLD} top_state_e;
  typedef enum logic [1:0] {M_IDLE, M_ACC, M_DIV, M_FIN} merge_state_e;

  typedef struct packed {
    logic [WeightW-1:0] outer_w;
    logic [WeightW-1:0] inner_w;
    logic [SampleW-1:0] max_p;
    logic [WeightW-1:0] arm_th;
    logic [WeightW-1:0] hc_w;
    logic [WeightW-1:0] hc_v;
    logic [WeightW-1:0] lc_w;
    logic [WeightW-1:0] lc_v;
  } cfg_t;

  typedef struct packed {
    logic                predicted;
    logic                switched;
    logic [SupportW-1:0] support;
  } result_t;

  // left fl/bl and right fr/br are outer sensors
  function automatic logic is_outer(input logic [LaneIdxW-1:0] idx);
    return idx[0] == idx[2];
  endfunction

endpackage
`default_nettype wire

FILE: src/fse_lane.sv
// One sensor lane: clamp, running and next-window peaks, serial normaliser.
// Depends on fse_pkg.
`default_nettype none
module fse_lane
  import fse_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               swap_i,
  input  wire logic [SampleW-1:0] sample_i,
  input  wire logic [SampleW-1:0] max_p_i,
  output logic      [NormW-1:0]   norm_o,
  output logic                    done_o
);

  logic [SampleW-1:0]   peak_q, peak_d, next_q, next_d;
  logic [SampleW-1:0]   clamped, peak_sel, next_sel;
  logic [LaneSteps-1:0] div_q;
  logic [SampleW-1:0]   rem_q;
  logic [LaneCntW-1:0]  cnt_q;
  logic                 busy_q, done_q;
  logic [SampleW:0]     trial, diff;
  logic                 ge;

  assign clamped  = (sample_i > max_p_i) ? max_p_i : sample_i;
  assign peak_sel = swap_i ? next_q : peak_q;
  assign next_sel = swap_i ? PeakFloor : next_q;
  assign peak_d   = (clamped > peak_sel) ? clamped : peak_sel;
  assign next_d   = (clamped > next_sel) ? clamped : next_sel;

  assign trial = {rem_q, div_q[LaneSteps-1]};
  assign diff  = trial - {1'b0, peak_q};
  assign ge    = trial >= {1'b0, peak_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= PeakFloor;
      next_q <= PeakFloor;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        peak_q <= peak_d;
        next_q <= next_d;
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LaneCntW'(LaneSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division, quotient shifts in behind the dividend
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= {clamped, {FracW{1'b0}}};
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[SampleW-1:0] : trial[SampleW-1:0];
      div_q <= {div_q[LaneSteps-2:0], ge};
    end
  end

  assign norm_o = div_q[NormW-1:0];
  assign done_o = done_q;

endmodule
`default_nettype wire

FILE: src/fse_merge.sv
// Merging stage: weighted sum over lanes, serial signed divide, saturation,
// switch flag and switch prediction. Depends on fse_pkg.
`default_nettype none
module fse_merge
  import fse_pkg::*;
(
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [NumLanes-1:0][NormW-1:0]   norm_i,
  input  wire cfg_t                             cfg_i,
  output result_t                               result_o,
  output logic                                  switched_o,
  output logic                                  done_o
);

  merge_state_e state_q, state_d;
  logic                 acc_en, div_en, fin_en;
  logic [LaneIdxW-1:0]  idx_q;
  logic [MergeCntW-1:0] cnt_q;
  logic [TotalW-1:0]    total_q, total_d;
  logic signed [WsumW-1:0] wsum_q, wsum_d;
  logic [MagW-1:0]      dvd_q, mag_d;
  logic [TotalW-1:0]    rem_q;
  logic                 neg_q;
  logic [2*WeightW-1:0] prod;
  logic [WeightW-1:0]   w;
  logic [TotalW:0]      trial, diff;
  logic                 ge;

  logic signed [SupportW-1:0] rep_sup_q, hist1_q, s;
  logic rep_sw_q, ap_q, an_q, ap_d, an_d, sw_d, pred_d;
  logic signed [19:0] sx, px, h1x, a, b, ab;
  logic signed [19:0] arm, hcw, hcv, lcw, lcv;
  logic signed [23:0] a10, b7;
  result_t res_q;

  // ---- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      M_IDLE: if (start_i) state_d = M_ACC;
      M_ACC:  if (idx_q == LaneIdxW'(NumLanes - 1)) state_d = M_DIV;
      M_DIV:  if (cnt_q == MergeCntW'(MagW - 1)) state_d = M_FIN;
      M_FIN:  state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  // ---- outputs of the sequencer
  always_comb begin
    acc_en = 1'b0;
    div_en = 1'b0;
    fin_en = 1'b0;
    unique case (state_q)
      M_ACC:   acc_en = 1'b1;
      M_DIV:   div_en = 1'b1;
      M_FIN:   fin_en = 1'b1;
      default: ;
    endcase
  end

  // ---- accumulate
  assign w       = is_outer(idx_q) ? cfg_i.outer_w : cfg_i.inner_w;
  assign prod    = w * norm_i[idx_q];
  assign total_d = total_q + TotalW'(norm_i[idx_q]);
  assign wsum_d  = idx_q[2] ? wsum_q - $signed({4'b0, prod})
                            : wsum_q + $signed({4'b0, prod});
  assign mag_d   = wsum_d[WsumW-1] ? MagW'(-wsum_d) : MagW'(wsum_d);

  // ---- divide step
  assign trial = {rem_q, dvd_q[MagW-1]};
  assign diff  = trial - {1'b0, total_q};
  assign ge    = trial >= {1'b0, total_q};

  // ---- saturate
  always_comb begin
    if (!neg_q) s = (dvd_q > MagW'(32767)) ? 16'sh7FFF : $signed(dvd_q[SupportW-1:0]);
    else        s = (dvd_q > MagW'(32768)) ? 16'sh8000 : -$signed(dvd_q[SupportW-1:0]);
  end

  // ---- switch and prediction
  assign sx  = {{4{s[15]}}, s};
  assign px  = {{4{rep_sup_q[15]}}, rep_sup_q};
  assign h1x = {{4{hist1_q[15]}}, hist1_q};
  assign a   = sx - px;
  assign b   = px - h1x;
  assign ab  = a + b;
  assign a10 = {{4{a[19]}}, a} * 24'sd10;
  assign b7  = {{4{b[19]}}, b} * 24'sd7;
  assign arm = {5'b0, cfg_i.arm_th};
  assign hcw = {5'b0, cfg_i.hc_w};
  assign hcv = {5'b0, cfg_i.hc_v};
  assign lcw = {5'b0, cfg_i.lc_w};
  assign lcv = {5'b0, cfg_i.lc_v};

  always_comb begin
    ap_d = ap_q;
    an_d = an_q;
    if (sx > arm)       ap_d = 1'b1;
    else if (sx < -arm) an_d = 1'b1;
    if (sx < 0) ap_d = 1'b0;
    if (sx > 0) an_d = 1'b0;
    sw_d   = (rep_sup_q > 0 && s < 0) || (rep_sup_q < 0 && s > 0);
    pred_d = (an_d && ((sx > -hcw && ab > hcv) || (sx > -lcw && ab > lcv)) && a10 > b7) ||
             (ap_d && ((sx < hcw && ab < -hcv) || (sx < lcw && ab < -lcv)) && a10 < b7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= M_IDLE;
      idx_q     <= '0;
      cnt_q     <= '0;
      rep_sup_q <= '0;
      rep_sw_q  <= 1'b0;
      hist1_q   <= '0;
      ap_q      <= 1'b0;
      an_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start_i) idx_q <= '0;
      else if (acc_en) idx_q <= idx_q + 1'b1;
      if (acc_en) cnt_q <= '0;
      else if (div_en) cnt_q <= cnt_q + 1'b1;
      if (fin_en) begin
        if (total_q == '0) begin
          rep_sup_q <= '0;
          rep_sw_q  <= 1'b0;
        end else begin
          hist1_q   <= rep_sup_q;
          rep_sup_q <= s;
          rep_sw_q  <= sw_d;
          ap_q      <= ap_d;
          an_q      <= an_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      total_q <= '0;
      wsum_q  <= '0;
    end else if (acc_en) begin
      total_q <= total_d;
      wsum_q  <= wsum_d;
      dvd_q   <= mag_d;
      neg_q   <= wsum_d[WsumW-1];
      rem_q   <= '0;
    end else if (div_en) begin
      rem_q <= ge ? diff[TotalW-1:0] : trial[TotalW-1:0];
      dvd_q <= {dvd_q[MagW-2:0], ge};
    end
    if (fin_en) begin
      if (total_q == '0) begin
        res_q <= '0;
      end else begin
        res_q.support   <= s;
        res_q.switched  <= sw_d;
        res_q.predicted <= pred_d;
      end
    end
  end

  assign result_o   = res_q;
  assign switched_o = rep_sw_q;
  assign done_o     = fin_en;

endmodule
`default_nettype wire

FILE: src/foot_support_estimator.sv
// Foot support estimator: eight pressure lanes and a merging stage.
// Depends on fse_pkg, fse_lane and fse_merge.
//
// Use:
//  - Input channel s_axis: one frame per transfer, eight 16-bit Q4.12
//    pressures (left fl, fr, bl, br, right fl, fr, bl, br) and a 32-bit
//    millisecond timestamp.
//  - Output channel m_axis: one result per frame: signed Q2.14 support,
//    switched flag and predicted-switch flag.
//  - Config channel cfg_*: write register cfg_index_i with cfg_data_i;
//    always ready, to be used only while the block is idle.
// Flow: one frame at a time. The eight lanes normalise in parallel with
// a bit-serial divider, then the merge stage accumulates the lanes
// through one multiplier and divides serially.
// The next frame is taken as soon as the result sits in the output
// register, even if the receiver has not yet taken it; a stalled receiver
// holds the result, and the block then stalls once the next result is ready.
// Reset: peaks return to the floor value, history, arming and timestamps
// clear, registers take their defaults, and no result is pending.
`default_nettype none
module foot_support_estimator
  import fse_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // fields from bit 0: 8 x 16-bit pressures, frame_time
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // fields from bit 0: support[15:0], switched, predicted_switch, zero pad
  output logic [OutDataW-1:0]      m_axis_tdata,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  top_state_e state_q, state_d;
  cfg_t cfg_q;
  logic [TimeW-1:0] last_swap_q, frame_time, elapsed;
  logic accept, swap, lanes_done, merge_done, merge_switched, load_out;
  logic [NumLanes-1:0] lane_done;
  logic [NumLanes-1:0][NormW-1:0] norm;
  result_t merge_res;
  logic out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign frame_time = s_axis_tdata[InDataW-1 -: TimeW];
  assign elapsed    = frame_time - last_swap_q;
  // swap in the next-window peaks after a reported switch and a full period
  assign swap       = merge_switched && !elapsed[TimeW-1] && (elapsed > SwapPeriodMs);
  assign lanes_done = &lane_done;
  assign cfg_ready_o = 1'b1;

  // ---- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.outer_w <= 15'd16384;
      cfg_q.inner_w <= 15'd8192;
      cfg_q.max_p   <= 16'd20480;
      cfg_q.arm_th  <= 15'd8192;
      cfg_q.hc_w    <= 15'd4096;
      cfg_q.hc_v    <= 15'd1638;
      cfg_q.lc_w    <= 15'd1638;
      cfg_q.lc_v    <= 15'd820;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_OUTER_W: cfg_q.outer_w <= cfg_data_i[WeightW-1:0];
        CFG_INNER_W: cfg_q.inner_w <= cfg_data_i[WeightW-1:0];
        CFG_MAX_P:   cfg_q.max_p   <= cfg_data_i;
        CFG_ARM_TH:  cfg_q.arm_th  <= cfg_data_i[WeightW-1:0];
        CFG_HC_W:    cfg_q.hc_w    <= cfg_data_i[WeightW-1:0];
        CFG_HC_V:    cfg_q.hc_v    <= cfg_data_i[WeightW-1:0];
        CFG_LC_W:    cfg_q.lc_w    <= cfg_data_i[WeightW-1:0];
        CFG_LC_V:    cfg_q.lc_v    <= cfg_data_i[WeightW-1:0];
        default: ;
      endcase
    end
  end

  // ---- lanes
  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    fse_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .start_i  (accept),
      .swap_i   (swap),
      .sample_i (s_axis_tdata[i*SampleW +: SampleW]),
      .max_p_i  (cfg_q.max_p),
      .norm_o   (norm[i]),
      .done_o   (lane_done[i])
    );
  end

  fse_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (lanes_done && state_q == T_LANE),
    .norm_i     (norm),
    .cfg_i      (cfg_q),
    .result_o   (merge_res),
    .switched_o (merge_switched),
    .done_o     (merge_done)
  );

  // ---- sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE:  if (accept) state_d = T_LANE;
      T_LANE:  if (lanes_done) state_d = T_MERGE;
      T_MERGE: if (merge_done) state_d = T_HOLD;
      T_HOLD:  if (!out_valid_q || m_axis_tready) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  // ---- sequencer: outputs
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      T_IDLE:  s_axis_tready = 1'b1;
      T_HOLD:  load_out = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      last_swap_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && swap) last_swap_q <= frame_time;
      if (load_out) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // hold the result until the receiver takes it
  always_ff @(posedge clk_i) begin
    if (load_out) out_data_q <= OutDataW'(merge_res);
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

FILE: src/fse_checker.sv
// Port-level checks for the foot support estimator, bound to the top level.
// Depends on fse_pkg and foot_support_estimator.
`default_nettype none
module fse_checker
  import fse_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic                cfg_valid_i,
  input wire logic                cfg_ready_o
);

  // one frame at a time: busy right after a transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a frame is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // a zero support can never be a sign change
  a_zero_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[SupportW-1:0] == '0 |-> !m_axis_tdata[SupportW])
    else $error("switch reported with zero support");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:SupportW+2] == '0)
    else $error("result padding not zero");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind foot_support_estimator fse_checker u_fse_checker (.*);
`default_nettype wire
